FILE: rtl/core/vector_normalize_core_macros.svh
// Assertion macros for the vector normalize core checker.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef VECTOR_NORMALIZE_CORE_MACROS_SVH
`define VECTOR_NORMALIZE_CORE_MACROS_SVH

// Same-cycle implication.
`define VN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vector_normalize_core: check failed");

// Next-cycle implication.
`define VN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vector_normalize_core: check failed");

`endif

FILE: rtl/core/vn_pkg.sv
// Shared widths, constants and the per-item context type of the vector normalize core.
// No dependencies.
`default_nettype none

package vn_pkg;

    localparam int COMP_W     = 32;
    localparam int LANES      = 4;
    localparam int SQ_W       = 2 * COMP_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = ROOT_W + 1;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int QUO_W      = 32;
    localparam int DIV_STEPS  = QUO_W;
    localparam int EXP_W      = 6;
    localparam int IN_W       = LANES * COMP_W;
    localparam int OUT_W      = (LANES + 1) * COMP_W;
    localparam int W_LANE     = LANES - 1;

    localparam logic [QUO_W-1:0] ONE_Q30        = 32'h4000_0000;
    localparam logic [EXP_W-1:0] DIV_SHIFT_BASE = 6'd29;

    typedef logic [COMP_W-1:0] t_comp;

    // Travels with every item down the pipe.
    typedef struct packed {
        t_comp [LANES-1:0]  mag;
        logic [LANES-1:0]   neg;
        logic               use_w;
        t_comp              kept_w;
        logic               zero;
        logic [EXP_W-1:0]   e;      // k + 1 of the 4^k scaling
    } t_ctx;

endpackage

`default_nettype wire

FILE: rtl/core/vector_normalize_core.sv
// Vector normalize core: scales three or four Q16.16 components (per component_mode) to unit length, Q1.30 out.
// Depends on vn_pkg.
//
//  channel   dir  handshake                   payload
//  s (in)    in   i_s_tvalid / o_s_tready     i_s_tdata: comp_x, comp_y, comp_z, comp_w
//  m (out)   out  o_m_tvalid / i_m_tready     o_m_tdata, o_m_tuser: zero_length
//  cfg       in   i_cfg_valid / o_cfg_ready   i_cfg_data: component_mode
//
// One item per cycle sustained while the output register is empty or taken. Stages: magnitudes,
// squares, sum and normalize, then the square root (one root bit per stage), a dividend register,
// the divide (one quotient bit per stage, four lanes) and 1 output register.
// Synchronous active-low reset clears valid bits and component_mode.
// The whole pipe advances whenever the output register is empty or taken.
`default_nettype none

module vector_normalize_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_data,      // component_mode
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [vn_pkg::IN_W-1:0]  i_s_tdata,       // comp_x, comp_y, comp_z, comp_w
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [vn_pkg::OUT_W-1:0] o_m_tdata,       // unit_x, unit_y, unit_z, unit_w, kept_w
    output logic                     o_m_tuser        // zero_length
);
    import vn_pkg::*;

    logic adv;
    logic r_mode;

    assign o_cfg_ready = 1'b1;
    assign adv         = ~o_m_tvalid | i_m_tready;
    assign o_s_tready  = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // ---------------- stage 1: magnitudes ----------------
    t_ctx n_c1, r_c1;
    logic r_v1;

    always_comb begin
        t_comp raw;
        n_c1 = '0;
        for (int l = 0; l < LANES; l++) begin
            raw = i_s_tdata[l*COMP_W +: COMP_W];
            n_c1.neg[l] = raw[COMP_W-1];
            n_c1.mag[l] = raw[COMP_W-1] ? (~raw + 1'b1) : raw;
        end
        n_c1.use_w  = r_mode;
        n_c1.kept_w = i_s_tdata[W_LANE*COMP_W +: COMP_W];
    end

    // ---------------- stage 2: squares ----------------
    t_ctx r_c2;
    logic r_v2;
    logic [LANES-1:0][SQ_W-1:0] n_sq, r_sq;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_sq[l] = r_c1.mag[l] * r_c1.mag[l];
        end
        if (!r_c1.use_w) begin
            n_sq[W_LANE] = '0;
        end
    end

    // ---------------- stage 3/4: sum ----------------
    t_ctx r_c3, r_c4;
    logic r_v3, r_v4;
    logic [SQ_W:0] r_p0, r_p1;
    logic [SUM_W-1:0] r_sum;

    // ---------------- stage 5/6: normalize to [2^62, 2^64) ----------------
    t_ctx n_c5, r_c5, n_c6, r_c6;
    logic r_v5, r_v6;
    logic [SQ_W-1:0] n_sp5, r_sp5, n_sp6, r_sp6;

    always_comb begin
        n_c5      = r_c4;
        n_c5.zero = (r_sum == '0);
        n_sp5     = r_sum[SQ_W] ? r_sum[SUM_W-1:2] : r_sum[SQ_W-1:0];
        n_c5.e    = r_sum[SQ_W] ? EXP_W'(0) : EXP_W'(1);
        if (n_sp5[SQ_W-1 -: 32] == '0) begin
            n_sp5  = n_sp5 << 32;
            n_c5.e = n_c5.e + EXP_W'(16);
        end
        if (n_sp5[SQ_W-1 -: 16] == '0) begin
            n_sp5  = n_sp5 << 16;
            n_c5.e = n_c5.e + EXP_W'(8);
        end
        if (n_sp5[SQ_W-1 -: 8] == '0) begin
            n_sp5  = n_sp5 << 8;
            n_c5.e = n_c5.e + EXP_W'(4);
        end
    end

    always_comb begin
        n_c6  = r_c5;
        n_sp6 = r_sp5;
        if (n_sp6[SQ_W-1 -: 4] == '0) begin
            n_sp6  = n_sp6 << 4;
            n_c6.e = n_c6.e + EXP_W'(2);
        end
        if (n_sp6[SQ_W-1 -: 2] == '0) begin
            n_sp6  = n_sp6 << 2;
            n_c6.e = n_c6.e + EXP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c1  <= n_c1;
            r_c2  <= r_c1;
            r_sq  <= n_sq;
            r_c3  <= r_c2;
            r_p0  <= {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
            r_p1  <= {1'b0, r_sq[2]} + {1'b0, r_sq[3]};
            r_c4  <= r_c3;
            r_sum <= {1'b0, r_p0} + {1'b0, r_p1};
            r_c5  <= n_c5;
            r_sp5 <= n_sp5;
            r_c6  <= n_c6;
            r_sp6 <= n_sp6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    logic [SQ_W-1:0]   r_rad  [0:SQRT_STEPS-1];
    logic [REM_W-1:0]  r_rem  [0:SQRT_STEPS-1];
    logic [ROOT_W-1:0] r_root [0:SQRT_STEPS-1];
    t_ctx              r_sc   [0:SQRT_STEPS-1];
    logic              r_sv   [0:SQRT_STEPS-1];

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
        logic [SQ_W-1:0]   in_rad;
        logic [REM_W-1:0]  in_rem;
        logic [ROOT_W-1:0] in_root;
        t_ctx              in_ctx;
        logic              in_v;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (s == 0) begin : g_first
            assign in_rad  = r_sp6;
            assign in_rem  = '0;
            assign in_root = '0;
            assign in_ctx  = r_c6;
            assign in_v    = r_v6;
        end else begin : g_next
            assign in_rad  = r_rad[s-1];
            assign in_rem  = r_rem[s-1];
            assign in_root = r_root[s-1];
            assign in_ctx  = r_sc[s-1];
            assign in_v    = r_sv[s-1];
        end

        assign cur   = {in_rem, in_rad[SQ_W-1 -: 2]};
        assign trial = {1'b0, in_root, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rad[s]  <= in_rad << 2;
                r_rem[s]  <= ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
                r_root[s] <= {in_root[ROOT_W-2:0], ge};
                r_sc[s]   <= in_ctx;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s] <= 1'b0;
            end else if (adv) begin
                r_sv[s] <= in_v;
            end
        end
    end

    // ---------------- dividend: (mag << (30+k)) + R/2 ----------------
    logic [LANES-1:0][SQ_W-1:0] n_dd, r_dd;
    logic [ROOT_W-1:0] r_pr;
    t_ctx              r_pc;
    logic              r_pv;

    always_comb begin
        logic [EXP_W-1:0] sh;
        sh = DIV_SHIFT_BASE + r_sc[SQRT_STEPS-1].e;
        for (int l = 0; l < LANES; l++) begin
            n_dd[l] = (SQ_W'(r_sc[SQRT_STEPS-1].mag[l]) << sh)
                    + SQ_W'(r_root[SQRT_STEPS-1] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dd <= n_dd;
            r_pr <= r_root[SQRT_STEPS-1];
            r_pc <= r_sc[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (adv) begin
            r_pv <= r_sv[SQRT_STEPS-1];
        end
    end

    // ---------------- divide, one quotient bit per stage, four lanes ----------------
    logic [LANES-1:0][COMP_W-1:0] r_drem [0:DIV_STEPS-1];
    logic [LANES-1:0][COMP_W-1:0] r_dlow [0:DIV_STEPS-1];
    logic [LANES-1:0][QUO_W-1:0]  r_dq   [0:DIV_STEPS-1];
    logic [ROOT_W-1:0]            r_dr   [0:DIV_STEPS-1];
    t_ctx                         r_dc   [0:DIV_STEPS-1];
    logic                         r_dv   [0:DIV_STEPS-1];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        logic [LANES-1:0][COMP_W-1:0] in_rem, in_low, n_rem, n_low;
        logic [LANES-1:0][QUO_W-1:0]  in_q, n_q;
        logic [ROOT_W-1:0]            in_r;
        t_ctx                         in_ctx;
        logic                         in_v;

        if (s == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    in_rem[l] = r_dd[l][SQ_W-1 -: COMP_W];
                    in_low[l] = r_dd[l][COMP_W-1:0];
                end
            end
            assign in_q   = '0;
            assign in_r   = r_pr;
            assign in_ctx = r_pc;
            assign in_v   = r_pv;
        end else begin : g_next
            assign in_rem = r_drem[s-1];
            assign in_low = r_dlow[s-1];
            assign in_q   = r_dq[s-1];
            assign in_r   = r_dr[s-1];
            assign in_ctx = r_dc[s-1];
            assign in_v   = r_dv[s-1];
        end

        always_comb begin
            logic [COMP_W:0] t;
            logic            ge;
            for (int l = 0; l < LANES; l++) begin
                t        = {in_rem[l], in_low[l][COMP_W-1]};
                ge       = (t >= {1'b0, in_r});
                n_rem[l] = ge ? COMP_W'(t - {1'b0, in_r}) : t[COMP_W-1:0];
                n_q[l]   = {in_q[l][QUO_W-2:0], ge};
                n_low[l] = in_low[l] << 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_drem[s] <= n_rem;
                r_dlow[s] <= n_low;
                r_dq[s]   <= n_q;
                r_dr[s]   <= in_r;
                r_dc[s]   <= in_ctx;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else if (adv) begin
                r_dv[s] <= in_v;
            end
        end
    end

    // ---------------- saturate, sign, output register ----------------
    logic [OUT_W-1:0] n_out, r_out;
    logic             r_zero;
    logic             r_ov;

    always_comb begin
        t_ctx             c;
        logic [QUO_W-1:0] m;
        c = r_dc[DIV_STEPS-1];
        for (int l = 0; l < LANES; l++) begin
            m = (r_dq[DIV_STEPS-1][l] > ONE_Q30) ? ONE_Q30 : r_dq[DIV_STEPS-1][l];
            if (c.neg[l]) begin
                m = ~m + 1'b1;
            end
            if (c.zero || (l == W_LANE && !c.use_w)) begin
                m = '0;
            end
            n_out[l*COMP_W +: COMP_W] = m;
        end
        n_out[LANES*COMP_W +: COMP_W] = c.kept_w;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out  <= n_out;
            r_zero <= r_dc[DIV_STEPS-1].zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_dv[DIV_STEPS-1];
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out;
    assign o_m_tuser  = r_zero;

endmodule

`default_nettype wire

FILE: rtl/core/vn_check.sv
// Port-level checker for vector_normalize_core, bound into every vector_normalize_core instance.
// Depends on vn_pkg and vector_normalize_core_macros.svh.
`default_nettype none

`include "vector_normalize_core_macros.svh"

module vn_check (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_s_tready,
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [vn_pkg::OUT_W-1:0] o_m_tdata,
    input logic                     o_m_tuser
);
    import vn_pkg::*;

    logic [COMP_W-1:0] unit_x;
    logic [COMP_W-1:0] unit_w;
    logic              stalled;
    logic              x_in_rng;
    logic              w_in_rng;

    assign unit_x   = o_m_tdata[0 +: COMP_W];
    assign unit_w   = o_m_tdata[W_LANE*COMP_W +: COMP_W];
    assign stalled  = o_m_tvalid && !i_m_tready;
    assign x_in_rng = (unit_x[COMP_W-1 -: 2] == 2'b00) || (unit_x[COMP_W-1 -: 2] == 2'b11)
                   || (unit_x == ONE_Q30);
    assign w_in_rng = (unit_w[COMP_W-1 -: 2] == 2'b00) || (unit_w[COMP_W-1 -: 2] == 2'b11)
                   || (unit_w == ONE_Q30);

    // stalled item stays put
    `VN_ASSERT_NEXT(a_out_hold, stalled, o_m_tvalid && $stable({o_m_tuser, o_m_tdata}))
    // pipe freezes while the output waits
    `VN_ASSERT_NOW(a_in_stall, stalled, !o_s_tready)
    // zero length forces all unit components to zero
    `VN_ASSERT_NOW(a_zero_len, o_m_tvalid && o_m_tuser, o_m_tdata[IN_W-1:0] == '0)
    // unit_x and unit_w stay within [-1.0, 1.0] in Q1.30
    `VN_ASSERT_NOW(a_unit_rng, o_m_tvalid, x_in_rng && w_in_rng)

endmodule

bind vector_normalize_core vn_check u_vn_check (.*);

`default_nettype wire

FILE: tb/vector_normalize_core_test.sv
// Self-checking testbench for vector_normalize_core: random and directed vectors,
// both component modes, checked against an in-bench unit-length predictor.
// Depends on vn_pkg and the vector_normalize_core RTL.
`default_nettype none

module vector_normalize_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vn_pkg::*;

    localparam int LATENCY   = 72;
    localparam int CYC_LIMIT = 400000;

    // x sits in the lowest bits, as on tdata
    typedef struct packed {
        logic [31:0] w, z, y, x;
    } t_vec;

    typedef struct packed {
        logic [31:0] ux, uy, uz, uw, kw;
        logic        zl;
    } t_unit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic i_cfg_data = 1'b0;
    logic o_cfg_ready;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [IN_W-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;
    logic o_m_tuser;

    vector_normalize_core uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_vec  pending_vecs[$];
    t_unit expected_units[$];
    bit    mode_q = 1'b0;
    int    errors = 0;
    int    cycles = 0;
    int    vecs_sent = 0;
    int    units_seen = 0;
    int    zero_seen = 0;
    bit    hold_rx = 1'b0;
    int    hold_left = 0;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] rem, root, b;
        rem = v; root = 0; b = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic t_unit normalize(t_vec v, bit all4);
        logic [31:0]  c[4];
        logic [31:0]  mag[4];
        logic [127:0] s, num, q;
        logic [63:0]  sp, r;
        logic [31:0]  res[4];
        int k, n;
        t_unit u;
        c[0] = v.x; c[1] = v.y; c[2] = v.z; c[3] = v.w;
        n = all4 ? 4 : 3;
        s = 0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = c[i][31] ? (~c[i] + 32'd1) : c[i];
            if (c[i] == 32'h8000_0000) mag[i] = 32'h8000_0000;
            res[i] = 0;
        end
        for (int i = 0; i < n; i++) s = s + 128'(mag[i]) * 128'(mag[i]);
        u.kw = v.w;
        u.zl = (s == 0);
        if (s != 0) begin
            if (s[127:64] != 0) begin
                k = -1; sp = 64'(s >> 2);
            end else begin
                k = 0; sp = s[63:0];
                while (sp < (64'd1 << 62)) begin
                    sp = sp << 2; k++;
                end
            end
            r = isqrt(sp);
            if (r == 0) r = 1;
            for (int i = 0; i < n; i++) begin
                num = 128'(mag[i]) << (30 + k);
                q = (num + 128'(r >> 1)) / 128'(r);
                if (q > 128'(ONE_Q30)) q = 128'(ONE_Q30);
                res[i] = c[i][31] ? (32'd0 - q[31:0]) : q[31:0];
            end
        end
        u.ux = res[0]; u.uy = res[1]; u.uz = res[2]; u.uw = res[3];
        return u;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h (unit %0d)", what, got, want, units_seen);
    endtask

    // accept sampled at rising edge, used by the driver at the next falling edge
    logic o_s_tready_q = 1'b0;

    // driver
    int tx_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready_q) begin
                tx_gap = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0) tx_gap = 0;
            end
            if (!(i_s_tvalid && !o_s_tready_q)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_vecs.size() > 0) begin
                    i_s_tdata  <= pending_vecs.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        o_s_tready_q <= o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            t_vec v;
            v = i_s_tdata;
            expected_units.push_back(normalize(v, mode_q));
            vecs_sent++;
        end
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            t_unit got, want;
            got.ux = o_m_tdata[31:0];
            got.uy = o_m_tdata[63:32];
            got.uz = o_m_tdata[95:64];
            got.uw = o_m_tdata[127:96];
            got.kw = o_m_tdata[159:128];
            got.zl = o_m_tuser;
            if (expected_units.size() == 0) begin
                report("unexpected item", got.ux, '0);
            end else begin
                want = expected_units.pop_front();
                if (got.ux !== want.ux) report("unit_x", got.ux, want.ux);
                if (got.uy !== want.uy) report("unit_y", got.uy, want.uy);
                if (got.uz !== want.uz) report("unit_z", got.uz, want.uz);
                if (got.uw !== want.uw) report("unit_w", got.uw, want.uw);
                if (got.kw !== want.kw) report("kept_w", got.kw, want.kw);
                if (got.zl !== want.zl) report("zero_length", got.zl, want.zl);
            end
            units_seen++;
            if (got.zl) zero_seen++;
        end
    end

    // long receiver hold, counted here so the pipe backs up
    always @(posedge i_clk) begin
        if (hold_rx) begin
            hold_rx   = 1'b0;
            hold_left = 300;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    // receiver stalls
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (o_m_tvalid) rx_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
        end
    end

    task automatic wait_drain();
        while (pending_vecs.size() > 0 || i_s_tvalid || expected_units.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_mode(bit m);
        @(negedge i_clk);
        i_cfg_data  <= m;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mode_q = m;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            3: return $urandom() >> $urandom_range(0, 31);
            4: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_vec(logic [31:0] x, y, z, w);
        t_vec v;
        v.x = x; v.y = y; v.z = z; v.w = w;
        pending_vecs.push_back(v);
    endtask

    task automatic directed_set();
        push_vec(0, 0, 0, 0);
        push_vec(0, 0, 0, 32'h1234_5678);
        push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_vec(32'h0001_0000, 0, 0, 0);
        push_vec(0, 32'hffff_0000, 0, 0);
        push_vec(0, 0, 1, 0);
        push_vec(0, 0, 0, 32'hffff_ffff);
        push_vec(1, 1, 1, 1);
        push_vec(32'hffff_ffff, 1, 32'hffff_ffff, 1);
        push_vec(3, 4, 0, 12);
        push_vec(32'h8000_0000, 0, 0, 32'h7fff_ffff);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_set();
        wait_drain();
        write_mode(1'b1);
        directed_set();
        wait_drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_mode(ph[0]);
            if (ph == 2) hold_rx = 1'b1;
            for (int i = 0; i < 255; i++)
                push_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            wait_drain();
        end

        $display("%0d vectors sent, %0d results checked, %0d zero-length, both modes",
                 vecs_sent, units_seen, zero_seen);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
